// ----- rtl/mvfb_pkg.sv -----
package mvfb_pkg;

  localparam logic [7:0]  MAGIC_BYTE = 8'hFE;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam int unsigned MAX_BYTES  = 9;
  localparam int unsigned CNT_W      = $clog2(MAX_BYTES + 1);

  localparam logic REG_SYSTEM_ID    = 1'b0;
  localparam logic REG_COMPONENT_ID = 1'b1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_first;
    logic [7:0] msg_len;
    logic [7:0] msg_id;
    logic [7:0] crc_extra;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } out_item_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// ----- rtl/mavlink_v1_frame_builder.sv -----
// The first result byte of an accepted item appears in the cycle after it is accepted.
// Each item yields 0, 1, 3, 7 or 9 bytes, sent one per cycle from a result buffer while out_stall is low.
// Throughput: one item per cycle while items yield one byte; the input stalls
// while the result buffer holds more than one byte, or one byte that is stalled.
// Reset (rst_n, synchronous, active low): system and component id 1, sequence 0,
// CRC 0xFFFF, no frame open, result buffer empty.
module mavlink_v1_frame_builder
  import mvfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0]       sys_id_r, comp_id_r;
  logic [7:0]       seq_r, seq_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       extra_r, extra_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  out_item_t        buf_r   [MAX_BYTES];
  out_item_t        buf_nxt [MAX_BYTES];
  out_item_t        ld      [MAX_BYTES];
  logic [CNT_W-1:0] ld_cnt;

  logic        in_acc, out_take;
  logic [15:0] c1, c2, c3, c4, c5, c6, c7;
  logic [7:0]  rem_base, rem_after, extra_use;
  logic        done;

  assign out_valid = (cnt_r != '0);
  assign out_item  = buf_r[0];
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = (cnt_r > CNT_W'(1)) || ((cnt_r == CNT_W'(1)) && out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign c1 = crc_feed(CRC_INIT, in_item.msg_len);
  assign c2 = crc_feed(c1, seq_r);
  assign c3 = crc_feed(c2, sys_id_r);
  assign c4 = crc_feed(c3, comp_id_r);
  assign c5 = in_item.is_first ? crc_feed(c4, in_item.msg_id) : crc_r;
  assign c6 = crc_feed(c5, in_item.payload_byte);
  assign extra_use = in_item.is_first ? in_item.crc_extra : extra_r;
  assign c7 = crc_feed(c6, extra_use);

  assign rem_base  = in_item.is_first ? ((in_item.msg_len == 8'd0) ? 8'd1 : in_item.msg_len)
                                      : rem_r;
  assign rem_after = rem_base - 8'd1;
  assign done      = (rem_after == 8'd0);

  always_comb begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      ld[i] = '0;
    end
    ld_cnt    = '0;
    seq_nxt   = seq_r;
    crc_nxt   = crc_r;
    rem_nxt   = rem_r;
    extra_nxt = extra_r;
    priority if (in_item.is_first) begin
      ld[0] = '{frame_byte: MAGIC_BYTE, frame_end: 1'b0};
      ld[1] = '{frame_byte: in_item.msg_len, frame_end: 1'b0};
      ld[2] = '{frame_byte: seq_r, frame_end: 1'b0};
      ld[3] = '{frame_byte: sys_id_r, frame_end: 1'b0};
      ld[4] = '{frame_byte: comp_id_r, frame_end: 1'b0};
      ld[5] = '{frame_byte: in_item.msg_id, frame_end: 1'b0};
      ld[6] = '{frame_byte: in_item.payload_byte, frame_end: 1'b0};
      ld[7] = '{frame_byte: c7[7:0], frame_end: 1'b0};
      ld[8] = '{frame_byte: c7[15:8], frame_end: 1'b1};
      ld_cnt    = done ? CNT_W'(9) : CNT_W'(7);
      seq_nxt   = seq_r + 8'd1;
      extra_nxt = in_item.crc_extra;
      crc_nxt   = done ? c7 : c6;
      rem_nxt   = rem_after;
    end else if (rem_r != 8'd0) begin
      ld[0] = '{frame_byte: in_item.payload_byte, frame_end: 1'b0};
      ld[1] = '{frame_byte: c7[7:0], frame_end: 1'b0};
      ld[2] = '{frame_byte: c7[15:8], frame_end: 1'b1};
      ld_cnt  = done ? CNT_W'(3) : CNT_W'(1);
      crc_nxt = done ? c7 : c6;
      rem_nxt = rem_after;
    end else begin
      ld_cnt = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    cnt_nxt = cnt_r;
    priority if (in_acc) begin
      for (int i = 0; i < MAX_BYTES; i++) begin
        buf_nxt[i] = ld[i];
      end
      cnt_nxt = ld_cnt;
    end else if (out_take) begin
      for (int i = 0; i < MAX_BYTES - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_id_r  <= 8'd1;
      comp_id_r <= 8'd1;
      seq_r     <= 8'd0;
      crc_r     <= CRC_INIT;
      rem_r     <= 8'd0;
      extra_r   <= 8'd0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SYSTEM_ID:    sys_id_r  <= cfg_data;
          REG_COMPONENT_ID: comp_id_r <= cfg_data;
          default:          sys_id_r  <= sys_id_r;
        endcase
      end
      if (in_acc) begin
        seq_r   <= seq_nxt;
        crc_r   <= crc_nxt;
        rem_r   <= rem_nxt;
        extra_r <= extra_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BYTES; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BYTES))
    else $error("result buffer count out of range");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.frame_end |-> cnt_r == CNT_W'(1))
    else $error("frame end not on last buffered byte");

  a_magic_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.is_first |=> out_valid && out_item.frame_byte == MAGIC_BYTE)
    else $error("frame does not open with magic byte");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && !in_acc |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("result buffer did not advance");

endmodule
